// ===== sv/ffa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types and command codes of the first-fit allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

    localparam int ID_W   = 32;
    localparam int LEN_W  = 30;
    localparam int OP_W   = 5;

    typedef struct packed {
        logic             free;
        logic [ID_W-1:0]  owner;
        logic [LEN_W-1:0] len;
    } seg_t;

    localparam logic [OP_W-1:0] OP_NONE    = 5'd0;
    localparam logic [OP_W-1:0] OP_INIT    = 5'd1;
    localparam logic [OP_W-1:0] OP_LOAD    = 5'd2;
    localparam logic [OP_W-1:0] OP_F_START = 5'd3;
    localparam logic [OP_W-1:0] OP_REJECT  = 5'd4;
    localparam logic [OP_W-1:0] OP_RING_RD = 5'd5;
    localparam logic [OP_W-1:0] OP_EV_START= 5'd6;
    localparam logic [OP_W-1:0] OP_RD_IDX  = 5'd7;
    localparam logic [OP_W-1:0] OP_NEXT    = 5'd8;
    localparam logic [OP_W-1:0] OP_EV_HIT  = 5'd9;
    localparam logic [OP_W-1:0] OP_RD_RIGHT= 5'd10;
    localparam logic [OP_W-1:0] OP_MERGE_R = 5'd11;
    localparam logic [OP_W-1:0] OP_RD_LEFT = 5'd12;
    localparam logic [OP_W-1:0] OP_MERGE_L = 5'd13;
    localparam logic [OP_W-1:0] OP_WR_SEG  = 5'd14;
    localparam logic [OP_W-1:0] OP_EV_END  = 5'd15;
    localparam logic [OP_W-1:0] OP_FIT     = 5'd16;
    localparam logic [OP_W-1:0] OP_SHU_RD  = 5'd17;
    localparam logic [OP_W-1:0] OP_SHU_WR  = 5'd18;
    localparam logic [OP_W-1:0] OP_SPLIT   = 5'd19;
    localparam logic [OP_W-1:0] OP_PLACE   = 5'd20;
    localparam logic [OP_W-1:0] OP_SHD_RD  = 5'd21;
    localparam logic [OP_W-1:0] OP_SHD_WR  = 5'd22;
    localparam logic [OP_W-1:0] OP_SHD_END = 5'd23;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } cmd_t;

    typedef struct packed {
        logic fresh;
        logic bad;
        logic live_full;
        logic none_live;
        logic idx_end;
        logic ev_hit;
        logic has_right;
        logic has_left;
        logic q_free;
        logic fit;
        logic exact;
        logic shu_done;
        logic shd_done;
        logic out_free;
    } status_t;

endpackage

// ===== sv/ffa_dp.sv =====
// ----------------------------------------------------------------------------
// ffa_dp
// Segment table, id/address ring, counters and result register.
// ----------------------------------------------------------------------------
module ffa_dp
    import ffa_pkg::*;
#(
    parameter int MAX_SEGMENTS = 64,
    parameter int MAX_LIVE     = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             cmd,
    output status_t          st,
    input  logic [LEN_W-1:0] request_size,
    input  logic             cfg_we,
    input  logic [LEN_W-1:0] cfg_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [ID_W-1:0]  alloc_id,
    output logic [LEN_W-1:0] start_address,
    output logic [ID_W-1:0]  oldest_live_id,
    output logic             status
);

    localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int RW = (MAX_LIVE > 1) ? $clog2(MAX_LIVE) : 1;

    seg_t             mem [MAX_SEGMENTS];
    seg_t             mem_q;
    logic [LEN_W-1:0] ring [MAX_LIVE];
    logic [LEN_W-1:0] ring_q;

    logic [LEN_W-1:0] total_reg;
    logic [ID_W-1:0]  next_reg;
    logic [ID_W-1:0]  oldest_reg;
    logic [CW-1:0]    count_reg;
    logic             fresh_reg;
    logic [RW-1:0]    wp_reg;
    logic [RW-1:0]    rp_reg;
    logic             out_valid_reg;

    logic [CW-1:0]    idx_reg;
    logic [CW-1:0]    shk_reg;
    logic [LEN_W-1:0] sum_reg;
    logic [LEN_W-1:0] size_reg;
    logic [LEN_W-1:0] addr_reg;
    seg_t             seg_reg;
    logic [ID_W-1:0]  id_reg;
    logic [LEN_W-1:0] start_reg;
    logic [ID_W-1:0]  old_out_reg;
    logic             stat_reg;

    logic             we;
    logic [IW-1:0]    wa;
    seg_t             wd;
    logic             re;
    logic [IW-1:0]    ra;
    logic [CW-1:0]    idx_p1;
    logic [CW-1:0]    idx_m1;
    logic [CW-1:0]    shk_p1;
    logic [CW-1:0]    shk_m1;
    logic [RW-1:0]    wp_inc;
    logic [RW-1:0]    rp_inc;
    logic [ID_W-1:0]  live_cnt;

    assign idx_p1   = idx_reg + CW'(1);
    assign idx_m1   = idx_reg - CW'(1);
    assign shk_p1   = shk_reg + CW'(1);
    assign shk_m1   = shk_reg - CW'(1);
    assign wp_inc   = (wp_reg == RW'(MAX_LIVE - 1)) ? '0 : wp_reg + RW'(1);
    assign rp_inc   = (rp_reg == RW'(MAX_LIVE - 1)) ? '0 : rp_reg + RW'(1);
    assign live_cnt = next_reg - oldest_reg;

    always_comb
    begin
        st.fresh     = fresh_reg;
        st.bad       = (size_reg == '0) || (size_reg > total_reg);
        st.live_full = live_cnt >= ID_W'(MAX_LIVE);
        st.none_live = next_reg == oldest_reg;
        st.idx_end   = idx_reg >= count_reg;
        st.ev_hit    = !mem_q.free && (mem_q.owner == oldest_reg) && (sum_reg == addr_reg);
        st.has_right = idx_p1 < count_reg;
        st.has_left  = idx_reg != '0;
        st.q_free    = mem_q.free;
        st.exact     = mem_q.len == size_reg;
        st.fit       = mem_q.free && ((mem_q.len == size_reg) ||
                       ((mem_q.len > size_reg) && (count_reg < CW'(MAX_SEGMENTS))));
        st.shu_done  = shk_reg <= idx_reg;
        st.shd_done  = shk_reg >= count_reg;
        st.out_free  = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        we = 1'b0;
        wa = '0;
        wd = seg_reg;
        re = 1'b0;
        ra = idx_reg[IW-1:0];
        case (cmd.op)
            OP_INIT:
            begin
                we = 1'b1;
                wa = '0;
                wd = '{free: 1'b1, owner: '0, len: total_reg};
            end
            OP_RD_IDX:
            begin
                re = 1'b1;
            end
            OP_RD_RIGHT:
            begin
                re = 1'b1;
                ra = idx_p1[IW-1:0];
            end
            OP_RD_LEFT:
            begin
                re = 1'b1;
                ra = idx_m1[IW-1:0];
            end
            OP_MERGE_L:
            begin
                we = 1'b1;
                wa = idx_m1[IW-1:0];
                wd = '{free: 1'b1, owner: '0, len: mem_q.len + seg_reg.len};
            end
            OP_WR_SEG:
            begin
                we = 1'b1;
                wa = idx_reg[IW-1:0];
            end
            OP_SHU_RD, OP_SHD_RD:
            begin
                re = 1'b1;
                ra = shk_reg[IW-1:0];
            end
            OP_SHU_WR:
            begin
                we = 1'b1;
                wa = shk_p1[IW-1:0];
                wd = mem_q;
            end
            OP_SHD_WR:
            begin
                we = 1'b1;
                wa = shk_m1[IW-1:0];
                wd = mem_q;
            end
            OP_SPLIT:
            begin
                we = 1'b1;
                wa = idx_p1[IW-1:0];
                wd = '{free: 1'b1, owner: '0, len: seg_reg.len - size_reg};
            end
            OP_PLACE:
            begin
                we = 1'b1;
                wa = idx_reg[IW-1:0];
                wd = '{free: 1'b0, owner: next_reg, len: size_reg};
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (re)
        begin
            mem_q <= mem[ra];
        end
        if (cmd.op == OP_PLACE)
        begin
            ring[wp_reg] <= sum_reg;
        end
        if (cmd.op == OP_RING_RD)
        begin
            ring_q <= ring[rp_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:     size_reg <= request_size;
            OP_F_START:
            begin
                idx_reg <= '0;
                sum_reg <= '0;
            end
            OP_EV_START:
            begin
                addr_reg <= ring_q;
                idx_reg  <= '0;
                sum_reg  <= '0;
            end
            OP_NEXT:
            begin
                sum_reg <= sum_reg + mem_q.len;
                idx_reg <= idx_p1;
            end
            OP_EV_HIT:   seg_reg <= '{free: 1'b1, owner: '0, len: mem_q.len};
            OP_MERGE_R:
            begin
                seg_reg.len <= seg_reg.len + mem_q.len;
                shk_reg     <= idx_reg + CW'(2);
            end
            OP_MERGE_L:  shk_reg <= idx_p1;
            OP_EV_END:
            begin
                idx_reg <= '0;
                sum_reg <= '0;
            end
            OP_FIT:
            begin
                seg_reg <= mem_q;
                shk_reg <= count_reg - CW'(1);
            end
            OP_SHU_WR:   shk_reg <= shk_m1;
            OP_SHD_WR:   shk_reg <= shk_p1;
            OP_PLACE:
            begin
                id_reg      <= next_reg;
                start_reg   <= sum_reg;
                old_out_reg <= oldest_reg;
                stat_reg    <= 1'b0;
            end
            OP_REJECT:
            begin
                id_reg      <= '0;
                start_reg   <= '0;
                old_out_reg <= oldest_reg;
                stat_reg    <= 1'b1;
            end
            default:
            begin
                seg_reg <= seg_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= LEN_W'(1048576);
            next_reg      <= ID_W'(1);
            oldest_reg    <= ID_W'(1);
            count_reg     <= CW'(1);
            fresh_reg     <= 1'b1;
            wp_reg        <= RW'(1 % MAX_LIVE);
            rp_reg        <= RW'(1 % MAX_LIVE);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (cmd.op)
                OP_INIT:    fresh_reg <= 1'b0;
                OP_EV_END:
                begin
                    oldest_reg <= oldest_reg + ID_W'(1);
                    rp_reg     <= rp_inc;
                end
                OP_SPLIT:   count_reg <= count_reg + CW'(1);
                OP_SHD_END: count_reg <= count_reg - CW'(1);
                OP_PLACE:
                begin
                    next_reg      <= next_reg + ID_W'(1);
                    wp_reg        <= wp_inc;
                    out_valid_reg <= 1'b1;
                end
                OP_REJECT:  out_valid_reg <= 1'b1;
                default:
                begin
                    fresh_reg <= fresh_reg;
                end
            endcase
            if (cfg_we)
            begin
                total_reg  <= cfg_data;
                oldest_reg <= next_reg;
                rp_reg     <= wp_reg;
                count_reg  <= CW'(1);
                fresh_reg  <= 1'b1;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign alloc_id       = id_reg;
    assign start_address  = start_reg;
    assign oldest_live_id = old_out_reg;
    assign status         = stat_reg;

endmodule

// ===== sv/ffa_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffa_ctrl
// Sequencer for search, eviction, merge and table shifts.
// ----------------------------------------------------------------------------
module ffa_ctrl
    import ffa_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t st,
    output cmd_t    cmd
);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_CHECK   = 5'd1;
    localparam logic [4:0] S_REJECT  = 5'd2;
    localparam logic [4:0] S_EV_RING = 5'd3;
    localparam logic [4:0] S_EV_ADDR = 5'd4;
    localparam logic [4:0] S_EV_RD   = 5'd5;
    localparam logic [4:0] S_EV_CHK  = 5'd6;
    localparam logic [4:0] S_EV_R1   = 5'd7;
    localparam logic [4:0] S_EV_R2   = 5'd8;
    localparam logic [4:0] S_EV_L1   = 5'd9;
    localparam logic [4:0] S_EV_L2   = 5'd10;
    localparam logic [4:0] S_EV_END  = 5'd11;
    localparam logic [4:0] S_F_RD    = 5'd12;
    localparam logic [4:0] S_F_CHK   = 5'd13;
    localparam logic [4:0] S_SHU_RD  = 5'd14;
    localparam logic [4:0] S_SHU_WR  = 5'd15;
    localparam logic [4:0] S_SPLIT   = 5'd16;
    localparam logic [4:0] S_PLACE   = 5'd17;
    localparam logic [4:0] S_SHD_RD  = 5'd18;
    localparam logic [4:0] S_SHD_WR  = 5'd19;

    logic [4:0] state_reg;
    logic [4:0] state_next;
    logic [4:0] ret_reg;
    logic [4:0] ret_next;

    assign in_ready = (state_reg == S_IDLE) && !st.fresh;

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cmd.op     = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (st.fresh)
                begin
                    cmd.op = OP_INIT;
                end
                else if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (st.bad)
                begin
                    state_next = S_REJECT;
                end
                else if (st.live_full)
                begin
                    state_next = S_EV_RING;
                end
                else
                begin
                    cmd.op     = OP_F_START;
                    state_next = S_F_RD;
                end
            end
            S_REJECT:
            begin
                if (st.out_free)
                begin
                    cmd.op     = OP_REJECT;
                    state_next = S_IDLE;
                end
            end
            S_EV_RING:
            begin
                cmd.op     = OP_RING_RD;
                state_next = S_EV_ADDR;
            end
            S_EV_ADDR:
            begin
                cmd.op     = OP_EV_START;
                state_next = S_EV_RD;
            end
            S_EV_RD:
            begin
                if (st.idx_end)
                begin
                    state_next = S_EV_END;
                end
                else
                begin
                    cmd.op     = OP_RD_IDX;
                    state_next = S_EV_CHK;
                end
            end
            S_EV_CHK:
            begin
                if (st.ev_hit)
                begin
                    cmd.op     = OP_EV_HIT;
                    state_next = S_EV_R1;
                end
                else
                begin
                    cmd.op     = OP_NEXT;
                    state_next = S_EV_RD;
                end
            end
            S_EV_R1:
            begin
                if (st.has_right)
                begin
                    cmd.op     = OP_RD_RIGHT;
                    state_next = S_EV_R2;
                end
                else
                begin
                    state_next = S_EV_L1;
                end
            end
            S_EV_R2:
            begin
                if (st.q_free)
                begin
                    cmd.op     = OP_MERGE_R;
                    ret_next   = S_EV_L1;
                    state_next = S_SHD_RD;
                end
                else
                begin
                    state_next = S_EV_L1;
                end
            end
            S_EV_L1:
            begin
                if (st.has_left)
                begin
                    cmd.op     = OP_RD_LEFT;
                    state_next = S_EV_L2;
                end
                else
                begin
                    cmd.op     = OP_WR_SEG;
                    state_next = S_EV_END;
                end
            end
            S_EV_L2:
            begin
                if (st.q_free)
                begin
                    cmd.op     = OP_MERGE_L;
                    ret_next   = S_EV_END;
                    state_next = S_SHD_RD;
                end
                else
                begin
                    cmd.op     = OP_WR_SEG;
                    state_next = S_EV_END;
                end
            end
            S_EV_END:
            begin
                cmd.op     = OP_EV_END;
                state_next = S_F_RD;
            end
            S_F_RD:
            begin
                if (st.idx_end)
                begin
                    state_next = st.none_live ? S_REJECT : S_EV_RING;
                end
                else
                begin
                    cmd.op     = OP_RD_IDX;
                    state_next = S_F_CHK;
                end
            end
            S_F_CHK:
            begin
                if (st.fit)
                begin
                    cmd.op     = OP_FIT;
                    state_next = st.exact ? S_PLACE : S_SHU_RD;
                end
                else
                begin
                    cmd.op     = OP_NEXT;
                    state_next = S_F_RD;
                end
            end
            S_SHU_RD:
            begin
                if (st.shu_done)
                begin
                    state_next = S_SPLIT;
                end
                else
                begin
                    cmd.op     = OP_SHU_RD;
                    state_next = S_SHU_WR;
                end
            end
            S_SHU_WR:
            begin
                cmd.op     = OP_SHU_WR;
                state_next = S_SHU_RD;
            end
            S_SPLIT:
            begin
                cmd.op     = OP_SPLIT;
                state_next = S_PLACE;
            end
            S_PLACE:
            begin
                if (st.out_free)
                begin
                    cmd.op     = OP_PLACE;
                    state_next = S_IDLE;
                end
            end
            S_SHD_RD:
            begin
                if (st.shd_done)
                begin
                    cmd.op     = OP_SHD_END;
                    state_next = ret_reg;
                end
                else
                begin
                    cmd.op     = OP_SHD_RD;
                    state_next = S_SHD_WR;
                end
            end
            S_SHD_WR:
            begin
                cmd.op     = OP_SHD_WR;
                state_next = S_SHD_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

endmodule

// ===== sv/first_fit_allocator_fifo_evict.sv =====
// ----------------------------------------------------------------------------
// first_fit_allocator_fifo_evict
// First-fit allocator over an address-ordered segment table with
// oldest-first eviction and coalescing of free neighbors.
//
// Input channel (in_valid/in_ready, request_size) takes one word per
// request. Output channel (out_valid/out_ready) returns alloc_id,
// start_address, oldest_live_id and status (1 = rejected).
// cfg_we/cfg_data write total_size; the user must write it only while
// idle, as the block itself does not enforce this. The write frees all
// allocations and resets the table to one free segment.
// One request is in flight at a time. A search pass reads and checks
// the segments in address order; an eviction scans the table for the
// oldest allocation, and a merge or a split shifts table entries one at
// a time through the single-port segment memory with registered read.
// After reset (and after a size write) entry 0 is rewritten before the
// next request is taken. When the receiver stalls, the result is held
// in the output register; a new request is taken meanwhile and waits
// before its own result is written.
// ----------------------------------------------------------------------------
module first_fit_allocator_fifo_evict
    import ffa_pkg::*;
#(
    parameter int MAX_SEGMENTS = 64,
    parameter int MAX_LIVE     = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [LEN_W-1:0] request_size,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [ID_W-1:0]  alloc_id,
    output logic [LEN_W-1:0] start_address,
    output logic [ID_W-1:0]  oldest_live_id,
    output logic             status,
    input  logic             cfg_we,
    input  logic [LEN_W-1:0] cfg_data
);

    cmd_t    cmd;
    status_t st;

    ffa_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    ffa_dp #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .MAX_LIVE     (MAX_LIVE)
    ) u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .st             (st),
        .request_size   (request_size),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .alloc_id       (alloc_id),
        .start_address  (start_address),
        .oldest_live_id (oldest_live_id),
        .status         (status)
    );

endmodule
